// ===== design/stbl_pkg.sv =====
package stbl_pkg;

    localparam int CODE_W  = 32;
    localparam int KWL_W   = 64;
    localparam int KWH_W   = 56;
    localparam int ENTRY_W = CODE_W + KWL_W + KWH_W;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } stbl_status_t;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_LOOKUP = 1'b1
    } stbl_func_t;

    // controller to datapath
    typedef struct packed {
        logic         load_item;
        logic         ins_read;
        logic         ins_shift;
        logic         ins_write;
        logic         lk_read;
        logic         lk_update;
        logic         set_status;
        stbl_status_t status;
        logic         res_load;
    } stbl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_lookup;
        logic full;
        logic pos_zero;
        logic prev_greater;
        logic range_ok;
        logic key_eq;
        logic out_free;
    } stbl_sts_t;

endpackage

// ===== design/stbl_if.sv =====
interface stbl_in_if;
    import stbl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     func;
    logic signed [CODE_W-1:0] code;
    logic [KWL_W-1:0]         keyword_low;
    logic [KWH_W-1:0]         keyword_high;

    modport source (output valid, output func, output code, output keyword_low,
                    output keyword_high, input ready);
    modport sink   (input valid, input func, input code, input keyword_low,
                    input keyword_high, output ready);
endinterface

interface stbl_out_if;
    import stbl_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [KWL_W-1:0] found_keyword_low;
    logic [KWH_W-1:0] found_keyword_high;

    modport source (output valid, output status, output found_keyword_low,
                    output found_keyword_high, input ready);
    modport sink   (input valid, input status, input found_keyword_low,
                    input found_keyword_high, output ready);
endinterface

// ===== design/sorted_table_binary_lookup.sv =====
// lookup: each probe reads the ram, then compares; the range halves until a match or it empties
// insert: larger entries are read and shifted up one at a time, then the item is written;
// a full table answers ST_FULL without touching the ram
// one request at a time, taken only while the controller is idle; results leave through an
// output register, so the next request is taken while a result waits
// reset (async, active low) empties the table and clears the output valid;
// table contents are not cleared and need no sweep
module sorted_table_binary_lookup #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    stbl_in_if.sink    in_ch,
    stbl_out_if.source out_ch
);
    import stbl_pkg::*;

    stbl_cmd_t cmd;
    stbl_sts_t sts;

    stbl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    stbl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .in_func          (in_ch.func),
        .in_code          (in_ch.code),
        .in_keyword_low   (in_ch.keyword_low),
        .in_keyword_high  (in_ch.keyword_high),
        .out_valid        (out_ch.valid),
        .out_ready        (out_ch.ready),
        .out_status       (out_ch.status),
        .out_keyword_low  (out_ch.found_keyword_low),
        .out_keyword_high (out_ch.found_keyword_high)
    );

endmodule

// ===== design/stbl_ram.sv =====
module stbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port, read data holds between reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/stbl_ctrl.sv =====
module stbl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  stbl_pkg::stbl_sts_t sts,
    output stbl_pkg::stbl_cmd_t cmd
);
    import stbl_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_INS_RD  = 7'b0000010,
        S_INS_CMP = 7'b0000100,
        S_INS_WR  = 7'b0001000,
        S_LK_RD   = 7'b0010000,
        S_LK_CMP  = 7'b0100000,
        S_FIN     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_INSERTED;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (sts.is_lookup)
                    begin
                        state_next = S_LK_RD;
                    end
                    else if (sts.full)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_FULL;
                        state_next     = S_FIN;
                    end
                    else
                    begin
                        state_next = S_INS_RD;
                    end
                end
            end
            S_INS_RD:
            begin
                if (sts.pos_zero)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    cmd.ins_read = 1'b1;
                    state_next   = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (sts.prev_greater)
                begin
                    cmd.ins_shift = 1'b1;
                    state_next    = S_INS_RD;
                end
                else
                begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                cmd.ins_write  = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = ST_INSERTED;
                state_next     = S_FIN;
            end
            S_LK_RD:
            begin
                if (sts.range_ok)
                begin
                    cmd.lk_read = 1'b1;
                    state_next  = S_LK_CMP;
                end
                else
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NOT_FOUND;
                    state_next     = S_FIN;
                end
            end
            S_LK_CMP:
            begin
                if (sts.key_eq)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_FOUND;
                    state_next     = S_FIN;
                end
                else
                begin
                    cmd.lk_update = 1'b1;
                    state_next    = S_LK_RD;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/stbl_dp.sv =====
module stbl_dp #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  stbl_pkg::stbl_cmd_t               cmd,
    output stbl_pkg::stbl_sts_t               sts,
    input  logic                              in_func,
    input  logic signed [stbl_pkg::CODE_W-1:0] in_code,
    input  logic [stbl_pkg::KWL_W-1:0]        in_keyword_low,
    input  logic [stbl_pkg::KWH_W-1:0]        in_keyword_high,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        out_status,
    output logic [stbl_pkg::KWL_W-1:0]        out_keyword_low,
    output logic [stbl_pkg::KWH_W-1:0]        out_keyword_high
);
    import stbl_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // item registers
    logic [CODE_W-1:0]  code_reg;
    logic [KWL_W-1:0]   kwl_reg;
    logic [KWH_W-1:0]   kwh_reg;

    // table and search control
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      pos_reg;
    logic [CW-1:0]      low_reg;
    logic [CW-1:0]      hp1_reg;
    logic [AW-1:0]      mid_reg;
    stbl_status_t       pend_reg;

    // output register
    logic               out_valid_reg;
    stbl_status_t       out_status_reg;
    logic [KWL_W-1:0]   out_kwl_reg;
    logic [KWH_W-1:0]   out_kwh_reg;

    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;

    logic [CW-1:0]      pos_dec;
    logic [CW:0]        mid_sum;
    logic [AW-1:0]      mid;
    logic [CODE_W-1:0]  rd_code;
    logic [CW-1:0]      mid_ext;

    assign pos_dec = pos_reg - CW'(1);
    assign mid_sum = {1'b0, low_reg} + {1'b0, hp1_reg} - (CW + 1)'(1);
    assign mid     = mid_sum[AW:1];
    assign mid_ext = CW'(mid_reg);
    assign rd_code = ram_rd_data[CODE_W-1:0];

    // memory port muxing
    always_comb
    begin
        ram_wr_en   = cmd.ins_shift | cmd.ins_write;
        ram_wr_addr = pos_reg[AW-1:0];
        ram_wr_data = cmd.ins_shift ? ram_rd_data : {kwh_reg, kwl_reg, code_reg};
        ram_rd_en   = cmd.ins_read | cmd.lk_read;
        ram_rd_addr = cmd.lk_read ? mid : pos_dec[AW-1:0];
    end

    stbl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // status back to the controller
    always_comb
    begin
        sts.is_lookup    = (in_func == FUNC_LOOKUP);
        sts.full         = (count_reg == CW'(TABLE_DEPTH));
        sts.pos_zero     = (pos_reg == '0);
        sts.prev_greater = ($signed(rd_code) > $signed(code_reg));
        sts.range_ok     = (low_reg < hp1_reg);
        sts.key_eq       = (rd_code == code_reg);
        sts.out_free     = !out_valid_reg || out_ready;
    end

    // item and search registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            code_reg <= in_code;
            kwl_reg  <= in_keyword_low;
            kwh_reg  <= in_keyword_high;
            pos_reg  <= count_reg;
            low_reg  <= '0;
            hp1_reg  <= count_reg;
        end
        if (cmd.ins_shift)
        begin
            pos_reg <= pos_dec;
        end
        if (cmd.lk_read)
        begin
            mid_reg <= mid;
        end
        if (cmd.lk_update)
        begin
            if ($signed(rd_code) > $signed(code_reg))
            begin
                hp1_reg <= mid_ext;
            end
            else
            begin
                low_reg <= mid_ext + CW'(1);
            end
        end
        if (cmd.set_status)
        begin
            pend_reg <= cmd.status;
        end
        if (cmd.res_load)
        begin
            out_status_reg <= pend_reg;
            out_kwl_reg    <= (pend_reg == ST_FOUND) ? ram_rd_data[CODE_W +: KWL_W] : '0;
            out_kwh_reg    <= (pend_reg == ST_FOUND) ?
                              ram_rd_data[CODE_W + KWL_W +: KWH_W] : '0;
        end
    end

    // entry count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ins_write)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_status       = out_status_reg;
    assign out_keyword_low  = out_kwl_reg;
    assign out_keyword_high = out_kwh_reg;

endmodule

// ===== design/stbl_checker.sv =====
module stbl_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [1:0]                 out_status,
    input logic [stbl_pkg::KWL_W-1:0] out_keyword_low,
    input logic [stbl_pkg::KWH_W-1:0] out_keyword_high
);
    import stbl_pkg::*;

    // a pending result stays until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // one request in flight: no request taken right after another
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while one is in progress");

    // keyword fields are zero unless the code was found
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status != ST_FOUND) |->
            (out_keyword_low == '0) && (out_keyword_high == '0))
        else $error("keyword not cleared for non-found result");

    // reset clears the result valid
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid during reset");

endmodule

bind sorted_table_binary_lookup stbl_checker u_stbl_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_keyword_low  (out_ch.found_keyword_low),
    .out_keyword_high (out_ch.found_keyword_high)
);

// ===== sim/sorted_table_binary_lookup_test.sv =====
`timescale 1ns / 100ps

module sorted_table_binary_lookup_test;
    import stbl_pkg::*;

    localparam int TABLE_DEPTH     = 256;
    localparam int RANDOM_REQUESTS = 1780;
    localparam int INSERT_PERCENT  = 35;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 600;
    localparam int STALL_LIMIT     = 20000;

    typedef struct {
        stbl_func_t               func;
        logic signed [CODE_W-1:0] code;
        logic [KWL_W-1:0]         keyword_low;
        logic [KWH_W-1:0]         keyword_high;
    } table_request_t;

    // mirror of the sorted table and the answers it owes
    class keyword_table_scoreboard;
        typedef struct {
            stbl_status_t     status;
            logic [KWL_W-1:0] keyword_low;
            logic [KWH_W-1:0] keyword_high;
        } table_answer_t;

        logic signed [CODE_W-1:0] code_mem [TABLE_DEPTH];
        logic [KWL_W-1:0]         word_low_mem [TABLE_DEPTH];
        logic [KWH_W-1:0]         word_high_mem [TABLE_DEPTH];
        int                       entries;
        int                       errors;
        table_answer_t            pending_answers [$];

        function new();
            entries = 0;
            errors  = 0;
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction

        // predict the answer to an accepted request and update the table
        function void note_request(table_request_t req);
            table_answer_t ans;
            int            pos;
            int            lo;
            int            hi;
            int            mid;
            bit            hit;
            ans.status       = ST_NOT_FOUND;
            ans.keyword_low  = '0;
            ans.keyword_high = '0;
            if (req.func == FUNC_INSERT)
            begin
                if (entries >= TABLE_DEPTH)
                begin
                    ans.status = ST_FULL;
                end
                else
                begin
                    // stable insert: only strictly larger codes move up
                    pos = entries;
                    while (pos > 0 && code_mem[pos-1] > req.code)
                    begin
                        code_mem[pos]      = code_mem[pos-1];
                        word_low_mem[pos]  = word_low_mem[pos-1];
                        word_high_mem[pos] = word_high_mem[pos-1];
                        pos--;
                    end
                    code_mem[pos]      = req.code;
                    word_low_mem[pos]  = req.keyword_low;
                    word_high_mem[pos] = req.keyword_high;
                    entries++;
                    ans.status = ST_INSERTED;
                end
            end
            else
            begin
                // binary search, stops at the first matching probe
                lo  = 0;
                hi  = entries - 1;
                hit = 1'b0;
                while (!hit && lo <= hi)
                begin
                    mid = (lo + hi) / 2;
                    if (code_mem[mid] == req.code)
                    begin
                        hit              = 1'b1;
                        ans.status       = ST_FOUND;
                        ans.keyword_low  = word_low_mem[mid];
                        ans.keyword_high = word_high_mem[mid];
                    end
                    else if (code_mem[mid] > req.code)
                    begin
                        hi = mid - 1;
                    end
                    else
                    begin
                        lo = mid + 1;
                    end
                end
            end
            pending_answers.push_back(ans);
        endfunction

        // compare one accepted result with the oldest answer
        function void check_answer(logic [1:0] status, logic [KWL_W-1:0] kwl,
                                   logic [KWH_W-1:0] kwh);
            table_answer_t ans;
            if (pending_answers.size() == 0)
            begin
                $error("result with no request waiting: status %0d", status);
                errors++;
                return;
            end
            ans = pending_answers.pop_front();
            if (status !== ans.status)
            begin
                $error("status: expected %0d, actual %0d", ans.status, status);
                errors++;
            end
            if (kwl !== ans.keyword_low)
            begin
                $error("found_keyword_low: expected %h, actual %h", ans.keyword_low, kwl);
                errors++;
            end
            if (kwh !== ans.keyword_high)
            begin
                $error("found_keyword_high: expected %h, actual %h", ans.keyword_high, kwh);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    stbl_in_if  in_ch ();
    stbl_out_if out_ch ();

    keyword_table_scoreboard sb = new();

    bit no_idle      = 1'b0;
    bit hold_request = 1'b0;
    int idle_cycles  = 0;

    sorted_table_binary_lookup #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // reset, released on a falling edge
    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic logic signed [CODE_W-1:0] pick_extreme_code();
        case ($urandom_range(0, 5))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            4:       return 32'sd1;
            default: return 32'sh8000_0001;
        endcase
    endfunction

    function automatic table_request_t make_request(stbl_func_t func,
                                                   logic signed [CODE_W-1:0] code,
                                                   logic [KWL_W-1:0] kwl,
                                                   logic [KWH_W-1:0] kwh);
        table_request_t req;
        req.func         = func;
        req.code         = code;
        req.keyword_low  = kwl;
        req.keyword_high = kwh;
        return req;
    endfunction

    function automatic logic [KWL_W-1:0] random_low();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [KWH_W-1:0] random_high();
        return KWH_W'({$urandom(), $urandom()});
    endfunction

    // offer one request after a random gap and wait until it is taken
    task automatic send_request(table_request_t req);
        int gap;
        gap = draw_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid        <= 1'b1;
        in_ch.func         <= req.func;
        in_ch.code         <= req.code;
        in_ch.keyword_low  <= req.keyword_low;
        in_ch.keyword_high <= req.keyword_high;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        sb.note_request(req);
    endtask

    // stimulus
    initial
    begin
        table_request_t           req;
        logic signed [CODE_W-1:0] inserted_codes [$];
        logic signed [CODE_W-1:0] code;
        int                       kind;
        in_ch.valid        = 1'b0;
        in_ch.func         = FUNC_INSERT;
        in_ch.code         = '0;
        in_ch.keyword_low  = '0;
        in_ch.keyword_high = '0;
        @(posedge rst_n);

        // empty table
        send_request(make_request(FUNC_LOOKUP, 32'sd0, '1, '1));
        send_request(make_request(FUNC_LOOKUP, 32'sh8000_0000, '0, '0));

        // code extremes, keyword extremes and duplicate codes
        send_request(make_request(FUNC_INSERT, 32'sh7fff_ffff, '1, '1));
        send_request(make_request(FUNC_INSERT, 32'sh8000_0000, '0, '0));
        send_request(make_request(FUNC_INSERT, 32'sd0, 64'h0000_0000_0044_4441,
                                  '0));
        send_request(make_request(FUNC_INSERT, 32'sd0, random_low(), random_high()));
        send_request(make_request(FUNC_INSERT, -32'sd1, random_low(), random_high()));
        send_request(make_request(FUNC_INSERT, 32'sd0, random_low(), random_high()));
        send_request(make_request(FUNC_INSERT, 32'sh8000_0000, '1, '0));

        // hits, and misses between stored codes
        send_request(make_request(FUNC_LOOKUP, 32'sh7fff_ffff, random_low(), '1));
        send_request(make_request(FUNC_LOOKUP, 32'sh8000_0000, random_low(), '0));
        send_request(make_request(FUNC_LOOKUP, 32'sd0, '0, '1));
        send_request(make_request(FUNC_LOOKUP, -32'sd1, '1, '0));
        send_request(make_request(FUNC_LOOKUP, 32'sd1, random_low(), random_high()));
        send_request(make_request(FUNC_LOOKUP, 32'sh7fff_fffe, random_low(),
                                  random_high()));
        send_request(make_request(FUNC_LOOKUP, 32'sh8000_0001, random_low(),
                                  random_high()));

        // random traffic: the table fills, then inserts meet a full table
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i % 100 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            // long output hold-off while requests keep coming back to back
            if (i == 500)
            begin
                no_idle      = 1'b1;
                hold_request = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < INSERT_PERCENT)
            begin
                if (kind < 15 && inserted_codes.size() > 0)
                    code = inserted_codes[$urandom_range(0, inserted_codes.size() - 1)];
                else if (kind < 25)
                    code = pick_extreme_code();
                else
                    code = $urandom();
                if (inserted_codes.size() < TABLE_DEPTH)
                    inserted_codes.push_back(code);
                req = make_request(FUNC_INSERT, code, random_low(), random_high());
            end
            else
            begin
                if (inserted_codes.size() == 0 || kind >= 90)
                    code = (kind >= 95) ? pick_extreme_code() : $urandom();
                else
                    code = inserted_codes[$urandom_range(0, inserted_codes.size() - 1)];
                if (kind >= 60 && kind < 75)
                    code = ($urandom_range(0, 1) == 0) ? code + 1 : code - 1;
                else if (kind >= 75 && kind < 90)
                    code = $urandom();
                req = make_request(FUNC_LOOKUP, code, random_low(), random_high());
            end
            send_request(req);
        end

        @(negedge clk);
        in_ch.valid <= 1'b0;

        // drain
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall        = HOLD_OFF_CYCLES;
            end
            else
            begin
                stall = draw_gap();
            end
            repeat (stall)
            begin
                @(negedge clk);
                out_ch.ready <= 1'b0;
            end
            @(negedge clk);
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (out_ch.valid !== 1'b1) @(posedge clk);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            sb.check_answer(out_ch.status, out_ch.found_keyword_low,
                            out_ch.found_keyword_high);
    end

    // watchdog on cycles with no request or result moving
    always @(posedge clk)
    begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

endmodule

// ===== files.f =====
design/stbl_pkg.sv
design/stbl_if.sv
design/stbl_ram.sv
design/stbl_ctrl.sv
design/stbl_dp.sv
design/sorted_table_binary_lookup.sv
design/stbl_checker.sv
sim/sorted_table_binary_lookup_test.sv
